// File: hdl/tgi_pkg.sv
// Shared types and constants of the trilinear grid interpolator.
// No dependencies; every other file of the block but tgi_ram imports this package.
package tgi_pkg;

  localparam int GRID_X_DEF    = 16;
  localparam int GRID_Y_DEF    = 16;
  localparam int GRID_Z_DEF    = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W      = 16;
  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 4096;
  localparam int IDX_W       = 8;
  localparam int COORD_W     = 32;
  localparam int CFG_AW      = 5;
  localparam int NUM_FIELDS  = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_X  = 3'd3;
  localparam logic [2:0] REG_SCALE_Y  = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;

  localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0100_0000;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] origin;
    logic [2:0][COORD_W-1:0] scale;
  } tgi_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       mem_we;
    logic       ld_query;
    logic       map_mul;
    logic       map_clamp;
    logic [1:0] axis;
    logic [2:0] corner;
    logic       rd_capture;
    logic [2:0] cap_idx;
    logic       lerp_lo;
    logic       lerp_hi;
    logic [2:0] op;
    logic       ld_out;
  } tgi_cmd_t;

endpackage

// File: hdl/tgi_if.sv
// Valid/ready channel interfaces for the item input and the result output.
// Depends on tgi_pkg for field widths.
interface tgi_in_if import tgi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ADDR_W-1:0]  point_index;
  logic [DATA_W-1:0]  vp_in;
  logic [DATA_W-1:0]  vs_in;
  logic [DATA_W-1:0]  rho_in;
  logic [COORD_W-1:0] query_x;
  logic [COORD_W-1:0] query_y;
  logic [COORD_W-1:0] query_z;

  modport source (output valid, cmd, point_index, vp_in, vs_in, rho_in,
                  query_x, query_y, query_z, input ready);
  modport sink (input valid, cmd, point_index, vp_in, vs_in, rho_in,
                query_x, query_y, query_z, output ready);
endinterface

interface tgi_out_if import tgi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] vp_result;
  logic [DATA_W-1:0] vs_result;
  logic [DATA_W-1:0] rho_result;

  modport source (output valid, vp_result, vs_result, rho_result, input ready);
  modport sink (input valid, vp_result, vs_result, rho_result, output ready);
endinterface

// File: hdl/tgi_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

// File: hdl/tgi_ctrl.sv
// Sequencer of the interpolator: axis mapping, corner reads, blend steps.
// Depends on tgi_pkg; drives the command struct of tgi_dp.
module tgi_ctrl import tgi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output tgi_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_MAP_MUL, S_MAP_CLAMP, S_READ, S_LERP_LO, S_LERP_HI, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.mem_we     = accept && (in_cmd == CMD_WRITE);
    cmd.ld_query   = accept && (in_cmd == CMD_QUERY);
    cmd.map_mul    = (state_r == S_MAP_MUL);
    cmd.map_clamp  = (state_r == S_MAP_CLAMP);
    cmd.axis       = axis_r;
    cmd.corner     = cnt_r[2:0];
    cmd.rd_capture = (state_r == S_READ) && (cnt_r != 4'd0);
    cmd.cap_idx    = 3'(cnt_r - 4'd1);
    cmd.lerp_lo    = (state_r == S_LERP_LO);
    cmd.lerp_hi    = (state_r == S_LERP_HI);
    cmd.op         = op_r;
    cmd.ld_out     = (state_r == S_FINISH) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.ld_query) begin
          state_nxt = S_MAP_MUL;
          axis_nxt  = 2'd0;
        end
      end
      S_MAP_MUL: state_nxt = S_MAP_CLAMP;
      S_MAP_CLAMP: begin
        if (axis_r == 2'd2) begin
          state_nxt = S_READ;
          cnt_nxt   = 4'd0;
        end else begin
          state_nxt = S_MAP_MUL;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      S_READ: begin
        if (cnt_r == 4'd8) begin
          state_nxt = S_LERP_LO;
          op_nxt    = 3'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_LERP_LO: state_nxt = S_LERP_HI;
      S_LERP_HI: begin
        if (op_r == 3'd6) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LERP_LO;
          op_nxt    = op_r + 3'd1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      cnt_r       <= 4'd0;
      op_r        <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_query_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_query |=> state_r == S_MAP_MUL)
    else $error("query accept did not start axis mapping");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("result overwrote an item not yet taken");

  a_last_op_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LERP_HI && op_r == 3'd6) |=> state_r == S_FINISH)
    else $error("blend sequence did not end after the last step");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

  a_read_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> cnt_r <= 4'd8)
    else $error("corner read counter ran past its end");
endmodule

// File: hdl/tgi_dp.sv
// Datapath: axis mapping multiplier, grid memories, corner queue and blender.
// Depends on tgi_pkg and tgi_ram; controlled by tgi_ctrl through tgi_cmd_t.
module tgi_dp import tgi_pkg::*; #(
  parameter int GRID_X    = GRID_X_DEF,
  parameter int GRID_Y    = GRID_Y_DEF,
  parameter int GRID_Z    = GRID_Z_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  tgi_cmd_t           cmd,
  input  tgi_cfg_t           cfg,
  input  logic [ADDR_W-1:0]  in_point_index,
  input  logic [DATA_W-1:0]  in_vp,
  input  logic [DATA_W-1:0]  in_vs,
  input  logic [DATA_W-1:0]  in_rho,
  input  logic [COORD_W-1:0] in_query_x,
  input  logic [COORD_W-1:0] in_query_y,
  input  logic [COORD_W-1:0] in_query_z,
  output logic [DATA_W-1:0]  out_vp,
  output logic [DATA_W-1:0]  out_vs,
  output logic [DATA_W-1:0]  out_rho
);
  localparam int FB  = FRAC_BITS;
  localparam int FW  = FB + 1;           // fraction, up to exactly one
  localparam int GW  = IDX_W + FB;       // grid coordinate
  localparam int VW  = DATA_W + FB;      // blended value
  localparam int DW  = VW + 1;           // signed difference
  localparam int HW  = DW - DATA_W;      // upper part of the difference
  localparam int SW  = 2 * FB + 18;      // blend sum
  localparam int PW  = 2 * COORD_W + 1;  // mapping product
  localparam int AXW = ADDR_W + IDX_W;
  localparam int KXY = (GRID_Y * GRID_Z) % STORE_DEPTH;
  localparam int KZ  = GRID_Z % STORE_DEPTH;

  // ---------------- axis mapping ----------------
  logic [COORD_W-1:0] q_r [3];
  logic [COORD_W-1:0] q_sel, org_sel, scl_sel;
  logic [8:0]         sz_sel;
  logic signed [COORD_W:0] dq;
  logic signed [PW-1:0]    prod, t_r, top, tc;
  logic [GW-1:0]    g;
  logic [IDX_W-1:0] i0, i0c, lo_nxt, hi_nxt;
  logic [GW-1:0]    g_rem;
  logic [FW-1:0]    fr_nxt;
  logic [IDX_W-1:0] lo_r [3];
  logic [IDX_W-1:0] hi_r [3];
  logic [FW-1:0]    fr_r [3];

  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      q_r[0] <= in_query_x;
      q_r[1] <= in_query_y;
      q_r[2] <= in_query_z;
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        q_sel = q_r[0]; org_sel = cfg.origin[0]; scl_sel = cfg.scale[0];
        sz_sel = 9'(GRID_X);
      end
      2'd1: begin
        q_sel = q_r[1]; org_sel = cfg.origin[1]; scl_sel = cfg.scale[1];
        sz_sel = 9'(GRID_Y);
      end
      default: begin
        q_sel = q_r[2]; org_sel = cfg.origin[2]; scl_sel = cfg.scale[2];
        sz_sel = 9'(GRID_Z);
      end
    endcase
  end

  assign dq   = $signed({q_sel[COORD_W-1], q_sel}) - $signed({org_sel[COORD_W-1], org_sel});
  assign prod = dq * $signed(scl_sel);

  always_ff @(posedge clk) begin
    if (cmd.map_mul) begin
      t_r <= prod;
    end
  end

  // Clamp to [0, size-1] in grid units, then split index and fraction.
  always_comb begin
    top = $signed({24'b0, 9'(sz_sel - 9'd1), 32'b0});
    if (t_r < 0) begin
      tc = '0;
    end else if (t_r > top) begin
      tc = top;
    end else begin
      tc = t_r;
    end
    g   = tc[IDX_W+31:32-FB];
    i0  = g[GW-1:FB];
    i0c = i0;
    if ({1'b0, i0} > 9'(sz_sel - 9'd2)) begin
      i0c = IDX_W'(sz_sel - 9'd2);
    end
    g_rem = g - {i0c, FB'(0)};
    if (sz_sel == 9'd1) begin
      lo_nxt = '0;
      hi_nxt = '0;
      fr_nxt = '0;
    end else begin
      lo_nxt = i0c;
      hi_nxt = i0c + IDX_W'(1);
      fr_nxt = g_rem[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_clamp) begin
      lo_r[cmd.axis] <= lo_nxt;
      hi_r[cmd.axis] <= hi_nxt;
      fr_r[cmd.axis] <= fr_nxt;
    end
  end

  // ---------------- corner addressing ----------------
  logic [IDX_W-1:0]  ix, iy, iz;
  logic [AXW-1:0]    flat;
  logic [ADDR_W-1:0] mem_addr;

  assign ix   = cmd.corner[0] ? hi_r[0] : lo_r[0];
  assign iy   = cmd.corner[1] ? hi_r[1] : lo_r[1];
  assign iz   = cmd.corner[2] ? hi_r[2] : lo_r[2];
  assign flat = AXW'(ix) * AXW'(KXY) + AXW'(iy) * AXW'(KZ) + AXW'(iz);
  assign mem_addr = cmd.mem_we ? in_point_index : flat[ADDR_W-1:0];

  // ---------------- blend step selection ----------------
  logic [FW-1:0] f_sel, f_r;
  logic [1:0]    stage;
  logic [SW-1:0] rnd;
  logic [2:0]    wr_idx;

  always_comb begin
    if (cmd.op < 3'd4) begin
      stage = 2'd0; f_sel = fr_r[0];
    end else if (cmd.op < 3'd6) begin
      stage = 2'd1; f_sel = fr_r[1];
    end else begin
      stage = 2'd2; f_sel = fr_r[2];
    end
    case (stage)
      2'd1:    rnd = SW'(1) << (FB - 1);
      2'd2:    rnd = SW'(1) << (2 * FB - 1);
      default: rnd = '0;
    endcase
  end

  assign wr_idx = 3'd6 - cmd.op;

  always_ff @(posedge clk) begin
    if (cmd.lerp_lo) begin
      f_r <= f_sel;
    end
  end

  logic [DATA_W-1:0] w_in  [NUM_FIELDS];
  logic [DATA_W-1:0] rdata [NUM_FIELDS];
  logic [DATA_W-1:0] res_q [NUM_FIELDS];

  assign w_in[0] = in_vp;
  assign w_in[1] = in_vs;
  assign w_in[2] = in_rho;

  for (genvar fi = 0; fi < NUM_FIELDS; fi++) begin : g_field
    logic [VW-1:0]            vq_r [8];
    logic signed [DW-1:0]     diff;
    logic [DATA_W+FW-1:0]     lo_prod_r;
    logic signed [HW-1:0]     dhi_r;
    logic [VW-1:0]            base_r;
    logic signed [HW+FW:0]    hi_prod;
    logic signed [SW-1:0]     sum;
    logic [VW-1:0]            res;

    tgi_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
      .clk   (clk),
      .we    (cmd.mem_we),
      .addr  (mem_addr),
      .wdata (w_in[fi]),
      .rdata (rdata[fi])
    );

    assign diff    = $signed({1'b0, vq_r[1]}) - $signed({1'b0, vq_r[0]});
    assign hi_prod = dhi_r * $signed({1'b0, f_r});
    assign sum     = $signed({2'b0, base_r, FB'(0)}) + $signed(SW'(lo_prod_r))
                   + (SW'(hi_prod) <<< DATA_W) + $signed(rnd);

    always_comb begin
      case (stage)
        2'd1:    res = sum[FB +: VW];
        2'd2:    res = VW'(sum[2*FB +: DATA_W]);
        default: res = sum[VW-1:0];
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd.lerp_lo) begin
        lo_prod_r <= diff[DATA_W-1:0] * f_sel;
        dhi_r     <= diff[DW-1:DATA_W];
        base_r    <= vq_r[0];
      end
    end

    // Queue of operands: pop two, push the blend at the tail.
    always_ff @(posedge clk) begin
      if (cmd.rd_capture) begin
        vq_r[cmd.cap_idx] <= VW'(rdata[fi]);
      end else if (cmd.lerp_hi) begin
        for (int i = 0; i < 6; i++) begin
          vq_r[i] <= vq_r[i+2];
        end
        vq_r[wr_idx] <= res;
      end
    end

    assign res_q[fi] = vq_r[0][DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_vp  <= res_q[0];
      out_vs  <= res_q[1];
      out_rho <= res_q[2];
    end
  end
endmodule

// File: hdl/trilinear_grid_interpolator.sv
// Top level of the trilinear grid interpolator: register file and wiring.
// Depends on tgi_pkg, tgi_if, tgi_ctrl, tgi_dp (which holds tgi_ram).
//
// Holds three 3D grids (p-velocity, s-velocity, density) of up to 4096
// points each, filled by write items at a flat index x*(ny*nz)+y*nz+z. A
// query item maps its world coordinate per axis as (q - origin) * scale,
// clamps it to the grid, and returns the trilinear blend of the eight
// surrounding points of each grid, rounded to nearest. A write item yields
// nothing. A query passes from acceptance to its result (plus any wait for
// the output slot) through the three axis mappings on one shared 33x32
// multiplier, the eight corner reads from the single-ported grid memories,
// the seven blend steps (each a split multiply in a low and a high step)
// and the load of the result register. One item is worked on at a time.
// Grid memories have no reset; query only points that were written.
module trilinear_grid_interpolator import tgi_pkg::*; #(
  parameter int GRID_X    = GRID_X_DEF,
  parameter int GRID_Y    = GRID_Y_DEF,
  parameter int GRID_Z    = GRID_Z_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  tgi_in_if.sink             in_ch,
  tgi_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [COORD_W-1:0] pwdata,
  output logic [COORD_W-1:0] prdata,
  output logic               pready
);
  tgi_cfg_t   cfg_r;
  tgi_cmd_t   cmd;
  logic       cfg_we;
  logic [2:0] reg_idx;

  // Register file: byte address 4*i holds register i.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin <= '0;
      cfg_r.scale  <= {3{SCALE_RESET}};
    end else if (cfg_we) begin
      case (reg_idx)
        REG_ORIGIN_X: cfg_r.origin[0] <= pwdata;
        REG_ORIGIN_Y: cfg_r.origin[1] <= pwdata;
        REG_ORIGIN_Z: cfg_r.origin[2] <= pwdata;
        REG_SCALE_X:  cfg_r.scale[0]  <= pwdata;
        REG_SCALE_Y:  cfg_r.scale[1]  <= pwdata;
        REG_SCALE_Z:  cfg_r.scale[2]  <= pwdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X: prdata = cfg_r.origin[0];
      REG_ORIGIN_Y: prdata = cfg_r.origin[1];
      REG_ORIGIN_Z: prdata = cfg_r.origin[2];
      REG_SCALE_X:  prdata = cfg_r.scale[0];
      REG_SCALE_Y:  prdata = cfg_r.scale[1];
      REG_SCALE_Z:  prdata = cfg_r.scale[2];
      default:      prdata = '0;
    endcase
  end

  // Sequencer: accepts an item only when idle, holds a finished result in
  // the output register until taken.
  tgi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath: mapping, grid memories, blending and result register.
  tgi_dp #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .cfg            (cfg_r),
    .in_point_index (in_ch.point_index),
    .in_vp          (in_ch.vp_in),
    .in_vs          (in_ch.vs_in),
    .in_rho         (in_ch.rho_in),
    .in_query_x     (in_ch.query_x),
    .in_query_y     (in_ch.query_y),
    .in_query_z     (in_ch.query_z),
    .out_vp         (out_ch.vp_result),
    .out_vs         (out_ch.vs_result),
    .out_rho        (out_ch.rho_result)
  );
endmodule
